@@ hdl/oli_pkg.sv @@
// Shared types and codes for the ordered list block.
package oli_pkg;

  localparam int IDX_W  = 5;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int POS_W  = 9;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_DELETE    = 3'd2,
    MODE_READ      = 3'd3,
    MODE_OVERWRITE = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic                     ins;
    logic                     del;
    logic                     wr;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         cnt;
    logic signed [DATA_W-1:0] value;
  } oli_cmd_t;

endpackage

@@ hdl/oli_cell.sv @@
// One storage cell of the shifting row; shifts up on insert, down on delete.
module oli_cell #(
  parameter int POS = 0
) (
  input  logic                             clk,
  input  oli_pkg::oli_cmd_t                cmd_i,
  input  logic signed [oli_pkg::DATA_W-1:0] left_i,
  input  logic signed [oli_pkg::DATA_W-1:0] right_i,
  output logic signed [oli_pkg::DATA_W-1:0] data_o
);
  import oli_pkg::*;

  localparam logic [POS_W-1:0] POS_V  = POS_W'(POS);
  localparam logic [POS_W-1:0] POS_P1 = POS_W'(POS + 1);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic [POS_W-1:0]         idx_w;
  logic [POS_W-1:0]         cnt_w;
  logic                     at_idx;
  logic                     above_idx;

  assign idx_w     = POS_W'(cmd_i.idx);
  assign cnt_w     = POS_W'(cmd_i.cnt);
  assign at_idx    = (POS_V == idx_w);
  assign above_idx = (POS_V > idx_w);

  always_comb begin
    data_nxt = data_r;
    if (cmd_i.ins) begin
      if (at_idx) begin
        data_nxt = cmd_i.value;
      end else if (above_idx && (POS_V <= cnt_w)) begin
        data_nxt = left_i;
      end
    end else if (cmd_i.del) begin
      // the deleted slot and entries past it pull from the right neighbor
      if ((at_idx || above_idx) && (POS_P1 < cnt_w)) begin
        data_nxt = right_i;
      end
    end else if (cmd_i.wr && at_idx) begin
      data_nxt = cmd_i.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

@@ hdl/ordered_list_insert_delete.sv @@
// Ordered list top level: a row of shifting cells under a request decoder.
// A request's result is registered, shown in the cycle after its transfer.
// One request per cycle unless stalled; every cell shifts in the same cycle.
// A held result does not stall input while out_ready is high.
// Reset (rst_n low, synchronous): count 0, capacity min(16, DEPTH), no result.
// Cell contents are not cleared; only positions below the count are readable.
module ordered_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_mode,
  input  logic [oli_pkg::IDX_W-1:0]           in_index,
  input  logic signed [oli_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [oli_pkg::DATA_W-1:0]   out_read_data,
  output logic [1:0]                          out_status,
  output logic [oli_pkg::CNT_W-1:0]           out_item_count,
  output logic                                out_is_full,
  output logic                                out_is_empty,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oli_pkg::CNT_W-1:0]           cfg_data
);
  import oli_pkg::*;

  localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((DEPTH < 16) ? DEPTH : 16);
  localparam logic [POS_W-1:0] DEPTH_V = POS_W'(DEPTH);
  localparam int               RD_N    = (DEPTH < 32) ? DEPTH : 32;

  logic [CNT_W-1:0]         cap_r;
  logic [CNT_W-1:0]         cap_nxt;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] rd_r;
  logic signed [DATA_W-1:0] rd_nxt;
  status_t                  status_r;
  status_t                  status_nxt;
  logic                     full_r;
  logic                     empty_r;

  logic                     in_xfer;
  logic                     cfg_xfer;
  logic                     full;
  mode_t                    mode;
  oli_cmd_t                 cmd;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] cell_rd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign full      = (cnt_r >= cap_r);
  assign mode      = mode_t'(in_mode);

  // capacity clamp: zero acts as one, above DEPTH acts as DEPTH
  always_comb begin
    cap_nxt = cap_r;
    if (cfg_xfer) begin
      priority if (cfg_data == '0) begin
        cap_nxt = CNT_W'(1);
      end else if (POS_W'(cfg_data) > DEPTH_V) begin
        cap_nxt = CNT_W'(DEPTH);
      end else begin
        cap_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    cell_rd = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (in_index == IDX_W'(i)) begin
        cell_rd = cell_q[i];
      end
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.idx    = in_index;
    cmd.cnt    = cnt_r;
    cmd.value  = in_value;
    cnt_nxt    = cnt_r;
    rd_nxt     = '0;
    status_nxt = ST_OK;
    unique case (mode)
      MODE_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins = in_xfer;
          cmd.idx = cnt_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        priority if (in_index > cnt_r) begin
          status_nxt = ST_BADIDX;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins = in_xfer;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (in_index >= cnt_r) begin
          status_nxt = ST_BADIDX;
        end else begin
          cmd.del = in_xfer;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (in_index >= cnt_r) begin
          status_nxt = ST_BADIDX;
        end else begin
          rd_nxt = cell_rd;
        end
      end
      MODE_OVERWRITE: begin
        if (in_index >= cnt_r) begin
          status_nxt = ST_BADIDX;
        end else begin
          cmd.wr = in_xfer;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w;
    logic signed [DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = in_value;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end
    oli_cell #(.POS(g)) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r <= cap_nxt;
      if (cfg_xfer) begin
        cnt_r <= '0;
      end else if (in_xfer) begin
        cnt_r <= cnt_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_r     <= rd_nxt;
      status_r <= status_nxt;
      full_r   <= (cnt_nxt >= cap_r);
      empty_r  <= (cnt_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_r;
  assign out_status     = status_r;
  assign out_item_count = cnt_r;
  assign out_is_full    = full_r;
  assign out_is_empty   = empty_r;

endmodule
